// ----- src/mhkd_pkg.sv -----
// ----------------------------------------------------------------------------
// mhkd_pkg
// Types and constants shared by the keyed-delete max-heap block.
// ----------------------------------------------------------------------------
package mhkd_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned DefKeyBits  = 32;
  localparam int unsigned IdBits      = 16;
  localparam int unsigned CountBits   = 7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] item_id;
    logic [31:0] mileage;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [31:0] out_mileage;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_RD2,
    S_DN_CMP,
    S_DN_WR,
    S_DONE
  } fsm_e;

endpackage

// ----- src/mhkd_ram.sv -----
// ----------------------------------------------------------------------------
// mhkd_ram
// Heap entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mhkd_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/max_heap_with_keyed_delete_core.sv -----
// ----------------------------------------------------------------------------
// max_heap_with_keyed_delete_core
// Binary max-heap of (id, key) entries with insert, extract and delete by id.
// Insert sifts up; extract moves the last entry to the root and sifts down;
// delete scans for the id, moves the last entry into that slot and sifts. One
// operation at a time; the single store port (one read, one write per cycle)
// sets the rate. Reset clears fill count, state, result valid; not the store.
// ----------------------------------------------------------------------------
module max_heap_with_keyed_delete_core
  import mhkd_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned KEY_BITS = DefKeyBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = IdBits + KEY_BITS;

  typedef logic [EW-1:0] ent_t;

  fsm_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;   // current index (always below CAPACITY)
  logic [CW-1:0] oth_q, oth_d;   // parent / chosen child index
  ent_t cur_q, cur_d;            // entry being sifted
  ent_t lc_q, lc_d;              // left child
  logic [1:0] op_q, op_d;
  logic [IdBits-1:0] id_q, id_d;
  logic [1:0] st_q, st_d;
  logic [IdBits-1:0] rid_q, rid_d;
  logic [KEY_BITS-1:0] rkey_q, rkey_d;
  logic ovld_q, ovld_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  ent_t wdata, rdata;

  mhkd_ram #(.Depth(CAPACITY), .Width(EW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [KEY_BITS-1:0] key_of(ent_t e);
    return e[KEY_BITS-1:0];
  endfunction

  logic [CW:0] lidx, ridx;
  logic [CW-1:0] par;
  assign lidx = {pos_q, 1'b1};
  assign ridx = {pos_q, 1'b0} + (CW+1)'(2);
  assign par  = (pos_q - CW'(1)) >> 1;

  assign in_stall_o  = (state_q != S_IDLE) || ovld_q;
  assign out_valid_o = ovld_q;
  always_comb begin
    out_data_o = '0;
    out_data_o.status = st_q;
    out_data_o.out_id = rid_q;
    out_data_o.out_mileage = 32'(rkey_q);
    out_data_o.entry_count = 7'(cnt_q);
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; pos_d = pos_q; oth_d = oth_q;
    cur_d = cur_q; lc_d = lc_q; op_d = op_q; id_d = id_q; st_d = st_q;
    rid_d = rid_q; rkey_d = rkey_q; ovld_d = ovld_q;
    we = 1'b0; waddr = '0; wdata = cur_q; raddr = '0;
    if (ovld_q && !out_stall_i) ovld_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !ovld_q) begin
          op_d = in_data_i.opcode; id_d = in_data_i.item_id;
          st_d = ST_OK; rid_d = '0; rkey_d = '0; pos_d = '0;
          raddr = '0;
          case (in_data_i.opcode)
            OP_INSERT: begin
              if (cnt_q >= CW'(CAPACITY)) begin
                st_d = ST_FULL; state_d = S_DONE;
              end else begin
                cur_d = {in_data_i.item_id, KEY_BITS'(in_data_i.mileage)};
                pos_d = cnt_q; cnt_d = cnt_q + CW'(1);
                state_d = S_UP_RD;
              end
            end
            OP_DELETE: begin
              if (cnt_q == '0) begin
                st_d = ST_NOT_FOUND; state_d = S_DONE;
              end else state_d = S_SCAN;
            end
            OP_EXTRACT: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY; state_d = S_DONE;
              end else state_d = S_MOVE_RD;  // root read issued
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        // rdata holds entry pos_q
        raddr = AW'(pos_q + CW'(1));
        if (rdata[EW-1:KEY_BITS] == id_q) begin
          raddr = AW'(cnt_q - CW'(1));
          cnt_d = cnt_q - CW'(1);
          if (pos_q == cnt_q - CW'(1)) state_d = S_DONE;
          else state_d = S_MOVE_WR;
        end else if (pos_q + CW'(1) >= cnt_q) begin
          st_d = ST_NOT_FOUND; state_d = S_DONE;
        end else pos_d = pos_q + CW'(1);
      end
      S_MOVE_RD: begin
        // root in rdata; read last
        rid_d = rdata[EW-1:KEY_BITS]; rkey_d = key_of(rdata);
        raddr = AW'(cnt_q - CW'(1));
        cnt_d = cnt_q - CW'(1);
        pos_d = '0;
        if (cnt_q == CW'(1)) state_d = S_DONE;
        else state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        // last entry in rdata, moves to pos_q
        cur_d = rdata;
        if (op_q == OP_DELETE && pos_q != '0) state_d = S_UP_RD;
        else state_d = S_DN_RD;
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          we = 1'b1; waddr = AW'(pos_q); state_d = S_DONE;
        end else begin
          raddr = AW'(par); oth_d = par; state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (key_of(rdata) < key_of(cur_q)) begin
          we = 1'b1; waddr = AW'(pos_q); wdata = rdata;
          pos_d = oth_q; state_d = S_UP_RD;
        end else begin
          we = 1'b1; waddr = AW'(pos_q);
          state_d = (op_q == OP_DELETE) ? S_DN_RD : S_DONE;
          // delete: parent not smaller means sift down
          if (op_q == OP_DELETE) state_d = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (lidx >= (CW+1)'(cnt_q)) begin
          we = 1'b1; waddr = AW'(pos_q); state_d = S_DONE;
        end else begin
          raddr = AW'(lidx); state_d = S_DN_RD2;
        end
      end
      S_DN_RD2: begin
        lc_d = rdata;
        raddr = AW'(ridx);
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        oth_d = pos_q;
        if (ridx < (CW+1)'(cnt_q) && key_of(rdata) > key_of(lc_q)
            && key_of(rdata) > key_of(cur_q)) begin
          oth_d = CW'(ridx); lc_d = rdata; state_d = S_DN_WR;
        end else if (key_of(lc_q) > key_of(cur_q)) begin
          oth_d = CW'(lidx); state_d = S_DN_WR;
        end else begin
          we = 1'b1; waddr = AW'(pos_q); state_d = S_DONE;
        end
      end
      S_DN_WR: begin
        we = 1'b1; waddr = AW'(pos_q); wdata = lc_q;
        pos_d = oth_q; state_d = S_DN_RD;
      end
      S_DONE: begin
        ovld_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; oth_q <= oth_d; cur_q <= cur_d; lc_q <= lc_d;
    op_q <= op_d; id_q <= id_d; st_q <= st_d; rid_q <= rid_d; rkey_q <= rkey_d;
  end

endmodule

// ----- src/mhkd_checker.sv -----
// ----------------------------------------------------------------------------
// mhkd_checker
// Port-level checks of the keyed-delete max-heap block.
// ----------------------------------------------------------------------------
module mhkd_checker
  import mhkd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
    out_data_o.out_id == '0 && out_data_o.out_mileage == '0)
    else $error("nonzero payload on error status");

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= 7'(DefCapacity))
    else $error("entry count out of range");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted two transfers back to back");

endmodule

bind max_heap_with_keyed_delete_core mhkd_checker u_mhkd_checker (.*);
